// ===== hw/rtl/ptcp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcp_pkg: shared types and constants
// Holds the job record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ptcp_pkg;

  localparam int CoordW = 24;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
  } ptcp_job_t;

  typedef struct packed {
    logic signed [15:0] sx0;
    logic signed [15:0] sy0;
    logic signed [15:0] sx1;
    logic signed [15:0] sy1;
  } ptcp_seg_t;

  localparam logic [2:0] RegRow0 = 3'd0;
  localparam logic [2:0] RegRow1 = 3'd1;
  localparam logic [2:0] RegRow2 = 3'd2;
  localparam logic [2:0] RegWidth = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;
  localparam logic [2:0] RegMode = 3'd5;

endpackage

// ===== hw/rtl/ptcp_div.sv =====
// ----------------------------------------------------------------------------
// ptcp_div: iterative signed divider
// Restoring division, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module ptcp_div #(
  parameter int NumW = 64,
  parameter int DenW = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DenW-1:0] den,
  output logic                   done,
  output logic signed [NumW-1:0] quo
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [NumW-1:0] dvd;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dmag;
  logic            neg;
  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], dvd[NumW-1]} - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
        dvd <= num[NumW-1] ? -num : num;
        dmag <= den[DenW-1] ? -den : den;
        neg <= num[NumW-1] ^ den[DenW-1];
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (!trial[DenW]) begin
          rem <= trial;
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= {rem[DenW-1:0], dvd[NumW-1]};
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -q : q;

endmodule

// ===== hw/rtl/ptcp_front.sv =====
// ----------------------------------------------------------------------------
// ptcp_front: vertex transform and segment classification
// Transforms one coordinate per cycle and pairs vertices into jobs.
// ----------------------------------------------------------------------------
module ptcp_front
  import ptcp_pkg::*;
#(
  parameter int FracBits = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        row [3],
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vx,
  input  logic signed [15:0] vy,
  input  logic signed [15:0] vz,
  input  logic               vfirst,
  output logic               job_valid,
  input  logic               job_ready,
  output ptcp_job_t          job
);

  typedef enum logic [1:0] {IDLE, CALC, SEND} state_t;

  state_t state;
  logic [1:0] r;
  logic signed [15:0] x, y, z;
  logic first;
  logic signed [CoordW-1:0] cur [3];
  logic signed [CoordW-1:0] prev [3];
  logic prev_valid;

  logic signed [15:0] m0, m1, m2, tr;
  logic signed [51:0] acc;
  logic signed [51:0] qt;
  logic signed [CoordW-1:0] sat;
  localparam logic signed [51:0] Max = 52'sd8388607;
  localparam logic signed [51:0] Min = -52'sd8388608;

  always_comb begin
    m0 = row[r][63:48];
    m1 = row[r][47:32];
    m2 = row[r][31:16];
    tr = row[r][15:0];
    acc = 52'(m0 * x) + 52'(m1 * y) + 52'(m2 * z) + (52'(tr) <<< FracBits);
    qt = acc[51] ? -((-acc) >>> FracBits) : (acc >>> FracBits);
    sat = (qt > Max) ? Max[CoordW-1:0] : (qt < Min) ? Min[CoordW-1:0] : qt[CoordW-1:0];
  end

  assign in_ready = (state == IDLE);
  assign job_valid = (state == SEND);
  assign job = '{prev[0], prev[1], prev[2], cur[0], cur[1], cur[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      prev_valid <= 1'b0;
      prev[0] <= '0;
      prev[1] <= '0;
      prev[2] <= '0;
    end else begin
      unique case (state)
        IDLE: if (in_valid) begin
          x <= vx;
          y <= vy;
          z <= vz;
          first <= vfirst;
          r <= 2'd0;
          state <= CALC;
        end
        CALC: begin
          cur[r] <= sat;
          if (r == 2'd2) begin
            if (first || !prev_valid) begin
              prev[0] <= cur[0];
              prev[1] <= cur[1];
              prev[2] <= sat;
              prev_valid <= 1'b1;
              state <= IDLE;
            end else begin
              state <= SEND;
            end
          end
          r <= r + 1'b1;
        end
        SEND: if (job_ready) begin
          prev[0] <= cur[0];
          prev[1] <= cur[1];
          prev[2] <= cur[2];
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ptcp_back.sv =====
// ----------------------------------------------------------------------------
// ptcp_back: clipping and projection
// Clips a segment at the near plane and projects both ends through one divider in perspective mode.
// ----------------------------------------------------------------------------
module ptcp_back
  import ptcp_pkg::*;
#(
  parameter int FracBits = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] width,
  input  logic [12:0] height,
  input  logic        persp,
  input  logic        job_valid,
  output logic        job_ready,
  input  ptcp_job_t   job,
  output logic        seg_valid,
  input  logic        seg_ready,
  output ptcp_seg_t   seg
);

  localparam int NearFx = ((1 << FracBits) * 5 + 50) / 100;
  localparam int OneFx = 1 << FracBits;

  typedef enum logic [2:0] {IDLE, CLIPX, CLIPY, PROJ, WAITD, OUT} state_t;

  state_t state;
  ptcp_job_t j;
  logic a_beh, b_beh;
  logic [1:0] k;
  logic signed [63:0] num;
  logic signed [39:0] den;
  logic start, done;
  logic signed [63:0] quo;
  logic signed [63:0] pquo;
  logic signed [63:0] mul_a, mul_b;
  logic signed [CoordW-1:0] cfar, cnear_diff;
  logic signed [CoordW:0] zdiff;
  logic signed [CoordW-1:0] px, py, pz;
  logic signed [15:0] res [4];
  logic signed [CoordW-1:0] base;
  logic signed [CoordW-1:0] clip_a;
  logic signed [39:0] zden;

  ptcp_div #(.NumW(64), .DenW(40)) u_div (
    .clk(clk), .rst(rst), .start(start), .num(num), .den(den),
    .done(done), .quo(quo)
  );

  always_comb begin
    px = k[1] ? j.bx : j.ax;
    py = k[1] ? j.by : j.ay;
    pz = k[1] ? j.bz : j.az;
    zden = (pz > 0) ? 40'(pz) * 40'sd20 : 40'(20 * NearFx);
    mul_a = 64'(px) + 64'(OneFx);
    mul_b = 64'(OneFx) - 64'(py);
    num = '0;
    den = 40'sd1;
    if (state == CLIPX || state == CLIPY) begin
      cfar = a_beh ? (state == CLIPX ? j.bx : j.by) : (state == CLIPX ? j.ax : j.ay);
      clip_a = a_beh ? (state == CLIPX ? j.ax : j.ay) : (state == CLIPX ? j.bx : j.by);
      cnear_diff = a_beh ? j.bz - CoordW'(NearFx) : j.az - CoordW'(NearFx);
      zdiff = a_beh ? 25'(j.bz) - 25'(j.az) : 25'(j.az) - 25'(j.bz);
      num = 64'(65'(clip_a) - 65'(cfar)) * 64'(cnear_diff);
      den = (zdiff <= 0) ? 40'sd1 : 40'(zdiff);
    end else begin
      cfar = '0;
      clip_a = '0;
      cnear_diff = '0;
      zdiff = '0;
      if (!persp) begin
        num = k[0] ? mul_b * 64'(height) : mul_a * 64'(width);
        den = 40'(2 * OneFx);
      end else begin
        num = k[0] ? (64'(pz) * 10 - 64'(py) * 3) * 64'(height)
                   : (64'(px) * 3 + 64'(pz) * 10) * 64'(width);
        den = zden;
      end
    end
    base = cfar;
    pquo = num[63] ? -((-num) >>> (FracBits + 1)) : (num >>> (FracBits + 1));
  end

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    return (v > 64'sd32767) ? 16'sd32767 : (v < -64'sd32768) ? -16'sd32768 : v[15:0];
  endfunction

  assign job_ready = (state == IDLE);
  assign seg_valid = (state == OUT);
  assign seg = '{res[0], res[1], res[2], res[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      unique case (state)
        IDLE: if (job_valid) begin
          j <= job;
          a_beh <= persp && (job.az < CoordW'(NearFx));
          b_beh <= persp && (job.bz < CoordW'(NearFx));
          k <= 2'd0;
          if (persp && job.az < CoordW'(NearFx) && job.bz < CoordW'(NearFx)) begin
            state <= IDLE;
          end else if (persp && (job.az < CoordW'(NearFx) || job.bz < CoordW'(NearFx))) begin
            state <= CLIPX;
            start <= 1'b1;
          end else begin
            state <= PROJ;
            start <= persp;
          end
        end
        CLIPX: if (done) begin
          if (a_beh) j.ax <= base + quo[CoordW-1:0];
          else j.bx <= base + quo[CoordW-1:0];
          state <= CLIPY;
          start <= 1'b1;
        end
        CLIPY: if (done) begin
          if (a_beh) begin
            j.ay <= base + quo[CoordW-1:0];
            j.az <= CoordW'(NearFx);
          end else begin
            j.by <= base + quo[CoordW-1:0];
            j.bz <= CoordW'(NearFx);
          end
          state <= PROJ;
          start <= 1'b1;
        end
        PROJ: if (!persp) begin
          res[k] <= sat16(pquo);
          k <= k + 1'b1;
          if (k == 2'd3) state <= OUT;
        end else if (done) begin
          res[k] <= sat16(quo);
          k <= k + 1'b1;
          if (k == 2'd3) state <= OUT;
          else start <= 1'b1;
        end
        OUT: if (seg_ready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/polyline_transform_clip_project.sv =====
// ----------------------------------------------------------------------------
// polyline_transform_clip_project: vertex transform, clip and projection
// Channel   Handshake    Payload
// vertex    push/full    px py pz first_vertex
// segment   pop/empty    start_sx start_sy end_sx end_sy
// config    cfg_we       cfg_index cfg_data
// The transform front end computes a vertex's coordinates in turn and takes no new vertex meanwhile.
// In perspective mode the back end does four projection divides per segment, plus
// two more when an end is clipped; the divider sets the rate.
// In parallel mode the back end projects by shifts, one coordinate per cycle.
// Reset restores the identity matrix, 640x480, parallel mode.
// A pending segment stalls the back end; the queue and the front end then hold a job each.
// ----------------------------------------------------------------------------
module polyline_transform_clip_project
  import ptcp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  input  logic signed [15:0] pz,
  input  logic               first_vertex,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] start_sx,
  output logic signed [15:0] start_sy,
  output logic signed [15:0] end_sx,
  output logic signed [15:0] end_sy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] row [3];
  logic [12:0] width, height;
  logic persp;
  logic in_ready, jv, jr, qv, qr;
  logic empty_n;
  ptcp_job_t job, qjob;
  ptcp_seg_t seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= 64'h1000_0000_0000_0000;
      row[1] <= 64'h0000_1000_0000_0000;
      row[2] <= 64'h0000_0000_1000_0000;
      width <= 13'd640;
      height <= 13'd480;
      persp <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRow0: row[0] <= cfg_data;
        RegRow1: row[1] <= cfg_data;
        RegRow2: row[2] <= cfg_data;
        RegWidth: width <= cfg_data[12:0];
        RegHeight: height <= cfg_data[12:0];
        RegMode: persp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  ptcp_front #(.FracBits(COORD_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .row(row), .in_valid(push), .in_ready(in_ready),
    .vx(px), .vy(py), .vz(pz), .vfirst(first_vertex),
    .job_valid(jv), .job_ready(jr), .job(job)
  );

  // One-entry job queue between front and back.
  always_ff @(posedge clk) begin
    if (rst) qv <= 1'b0;
    else if (jv && jr) qv <= 1'b1;
    else if (qr) qv <= 1'b0;
    if (jv && jr) qjob <= job;
  end
  assign jr = !qv;

  ptcp_back #(.FracBits(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .width(width), .height(height), .persp(persp),
    .job_valid(qv), .job_ready(qr), .job(qjob),
    .seg_valid(empty_n), .seg_ready(pop), .seg(seg)
  );

  assign empty = !empty_n;
  assign start_sx = seg.sx0;
  assign start_sy = seg.sy0;
  assign end_sx = seg.sx1;
  assign end_sy = seg.sy1;

  a_full: assert property (@(posedge clk) disable iff (rst) qv |-> !jr)
    else $error("queue accepted while occupied");
  a_deq: assert property (@(posedge clk) disable iff (rst) (qv && qr) |=> !qv)
    else $error("back end took a job twice");
  a_pop: assert property (@(posedge clk) disable iff (rst) (pop && !empty) |=> empty)
    else $error("segment held after pop");

endmodule

// ===== sim/tb_polyline_transform_clip_project.sv =====
// ----------------------------------------------------------------------------
// Polyline transform, clip and projection block regression
// Sends polyline vertices under several matrices, raster sizes and both
// projection modes and checks every segment against a predictor in this
// bench, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_polyline_transform_clip_project;
  import ptcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 12;
  localparam longint OneFx = 64'sd1 <<< FracBits;
  localparam longint NearFx = (OneFx * 5 + 50) / 100;
  localparam longint CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] px = '0;
  logic signed [15:0] py = '0;
  logic signed [15:0] pz = '0;
  logic first_vertex = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] start_sx, start_sy, end_sx, end_sy;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] row_q [3];
  longint width_q, height_q;
  bit persp_q;
  longint last_pt [3];
  bit last_valid;

  ptcp_seg_t segments_due [$];
  int errors = 0;
  int segments_seen = 0;
  int vertices_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  polyline_transform_clip_project dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("polyline_transform_clip_project regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic longint sat_to(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint row_coef(input int r, input int k);
    logic signed [15:0] f;
    f = row_q[r][63 - 16 * k -: 16];
    return longint'(f);
  endfunction

  task automatic screen_point(input longint p [3], output longint sx, output longint sy);
    longint vx, vy, den;
    if (!persp_q) begin
      vx = (p[0] + OneFx) * width_q / (2 * OneFx);
      vy = (OneFx - p[1]) * height_q / (2 * OneFx);
    end else begin
      den = 20 * p[2];
      if (den <= 0) den = 20 * NearFx;
      vx = (3 * p[0] + 10 * p[2]) * width_q / den;
      vy = (10 * p[2] - 3 * p[1]) * height_q / den;
    end
    sx = sat_to(vx, -32768, 32767);
    sy = sat_to(vy, -32768, 32767);
  endtask

  task automatic move_to_near(inout longint a [3], input longint b [3]);
    longint num, den;
    num = b[2] - NearFx;
    den = b[2] - a[2];
    if (den <= 0) den = 1;
    for (int i = 0; i < 2; i++) a[i] = b[i] + (a[i] - b[i]) * num / den;
    a[2] = NearFx;
  endtask

  task automatic predict_segment(input logic [15:0] x, y, z, input bit first);
    longint v [3], cur [3], a [3], b [3], acc;
    longint s0x, s0y, s1x, s1y;
    ptcp_seg_t seg;
    v[0] = longint'($signed(x));
    v[1] = longint'($signed(y));
    v[2] = longint'($signed(z));
    for (int r = 0; r < 3; r++) begin
      acc = row_coef(r, 3) * OneFx;
      for (int k = 0; k < 3; k++) acc += row_coef(r, k) * v[k];
      cur[r] = sat_to(acc / OneFx, -8388608, 8388607);
    end
    if (first || !last_valid) begin
      last_pt = cur;
      last_valid = 1'b1;
      return;
    end
    a = last_pt;
    b = cur;
    last_pt = cur;
    if (persp_q) begin
      if (a[2] < NearFx && b[2] < NearFx) return;
      if (a[2] < NearFx) move_to_near(a, b);
      else if (b[2] < NearFx) move_to_near(b, a);
    end
    screen_point(a, s0x, s0y);
    screen_point(b, s1x, s1y);
    seg.sx0 = s0x[15:0];
    seg.sy0 = s0y[15:0];
    seg.sx1 = s1x[15:0];
    seg.sy1 = s1y[15:0];
    segments_due.push_back(seg);
  endtask

  task automatic send_vertex(input logic [15:0] x, y, z, input bit first);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    px <= x;
    py <= y;
    pz <= z;
    first_vertex <= first;
    predict_segment(x, y, z, first);
    @(posedge clk);
    while (full) @(posedge clk);
    vertices_sent++;
  endtask

  always @(posedge clk) begin
    ptcp_seg_t want;
    if (!rst && pop && !empty) begin
      segments_seen++;
      if (segments_due.size() == 0) begin
        report_mismatch("segment with none expected");
      end else begin
        want = segments_due.pop_front();
        if (start_sx !== want.sx0)
          report_mismatch($sformatf("start_sx %0d want %0d", start_sx, want.sx0));
        if (start_sy !== want.sy0)
          report_mismatch($sformatf("start_sy %0d want %0d", start_sy, want.sy0));
        if (end_sx !== want.sx1)
          report_mismatch($sformatf("end_sx %0d want %0d", end_sx, want.sx1));
        if (end_sy !== want.sy1)
          report_mismatch($sformatf("end_sy %0d want %0d", end_sy, want.sy1));
      end
    end
    pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drain();
    push <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      RegRow0, RegRow1, RegRow2: row_q[idx] = val;
      RegWidth: width_q = longint'(val[12:0]);
      RegHeight: height_q = longint'(val[12:0]);
      RegMode: persp_q = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] coord_rand();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] coef_rand();
    case ($urandom_range(7))
      0: return 16'($urandom);
      1: return 16'h1000;
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic test_parallel_directed();
    send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h1000, 16'hf000, 16'h0000, 1'b0);
    send_vertex(16'h0800, 16'h0800, 16'h0100, 1'b1);
    send_vertex(16'hf800, 16'h0400, 16'h0100, 1'b0);
  endtask

  task automatic test_perspective_clip();
    write_reg(RegMode, 64'd1);
    send_vertex(16'h0400, 16'h0400, 16'h2000, 1'b1);
    send_vertex(16'hfc00, 16'h0200, 16'h1000, 1'b0);
    send_vertex(16'h0200, 16'h0100, 16'h0010, 1'b0);
    send_vertex(16'h0100, 16'h0100, 16'hf000, 1'b0);
    send_vertex(16'h0300, 16'h0300, 16'h1000, 1'b0);
    send_vertex(16'h0000, 16'h0000, 16'h00cd, 1'b0);
    send_vertex(16'h7fff, 16'h8000, 16'h00cc, 1'b0);
    send_vertex(16'h8000, 16'h7fff, 16'h7fff, 1'b0);
    send_vertex(16'h0001, 16'h0001, 16'h0001, 1'b0);
  endtask

  task automatic test_extreme_config();
    write_reg(RegWidth, 64'd4096);
    write_reg(RegHeight, 64'd1);
    write_reg(RegRow0, 64'h7fff_8000_7fff_8000);
    write_reg(RegRow1, 64'h8000_7fff_8000_7fff);
    write_reg(RegRow2, 64'hffff_ffff_ffff_ffff);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h0000, 16'h7fff, 16'h8000, 1'b0);
    write_reg(RegMode, 64'd0);
    write_reg(RegWidth, 64'd0);
    write_reg(RegHeight, 64'h1fff);
    send_vertex(16'h1234, 16'hedcb, 16'h0000, 1'b1);
    send_vertex(16'h8000, 16'h7fff, 16'h0000, 1'b0);
  endtask

  task automatic test_random_polylines(input int count);
    int left;
    left = count;
    while (left > 0) begin
      int len;
      len = $urandom_range(8, 1);
      for (int i = 0; i < len && left > 0; i++, left--) begin
        send_vertex(coord_rand(), coord_rand(), coord_rand(),
                    (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
      end
    end
  endtask

  task automatic new_setting(input int k);
    write_reg(RegMode, 64'($urandom_range(1)));
    write_reg(RegWidth, (k % 3 == 0) ? 64'd1 : 64'($urandom_range(4096, 1)));
    write_reg(RegHeight, (k % 3 == 1) ? 64'd4096 : 64'($urandom_range(4096, 1)));
    for (int r = 0; r < 3; r++) begin
      write_reg(RegRow0 + 3'(r), {coef_rand(), coef_rand(), coef_rand(), coef_rand()});
    end
  endtask

  task automatic test_backpressure();
    recv_stall_pct = 0;
    send_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random_polylines(40);
    join
  endtask

  initial begin
    row_q[0] = 64'd1 << 60;
    row_q[1] = 64'd1 << 44;
    row_q[2] = 64'd1 << 28;
    width_q = 640;
    height_q = 480;
    persp_q = 1'b0;
    last_valid = 1'b0;
    for (int i = 0; i < 3; i++) last_pt[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_parallel_directed();
    test_perspective_clip();
    test_extreme_config();
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      new_setting(k);
      test_random_polylines(130);
    end
    test_backpressure();
    drain();
    $display("Sent %0d vertices and checked %0d segments,", vertices_sent, segments_seen);
    $display("both projection modes, extreme sizes and matrices, with stalls.");
    if (errors == 0) begin
      $display("polyline_transform_clip_project regression: pass");
    end else begin
      $display("polyline_transform_clip_project regression: fail");
    end
    $finish;
  end
endmodule

// ===== polyline_transform_clip_project.f =====
hw/rtl/ptcp_pkg.sv
hw/rtl/ptcp_div.sv
hw/rtl/ptcp_front.sv
hw/rtl/ptcp_back.sv
hw/rtl/polyline_transform_clip_project.sv
sim/tb_polyline_transform_clip_project.sv
